FILE: hw/rtl/pvc_pkg.sv
// Shared constants and types for the printable Vigenere cipher unit.
package pvc_pkg;

  localparam int KEY_DEPTH = 64;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_LW    = $clog2(KEY_DEPTH + 1);
  localparam int KEY_W     = 7;

  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;
  localparam logic [8:0] PRINT_MOD = 9'd95;
  localparam logic [7:0] ESC_BYTE  = 8'd27;
  localparam logic [7:0] ESC_END   = 8'd109;

  localparam logic REG_ENCRYPT_MODE = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_REWIND = 2'd2,
    OP_TEXT   = 2'd3
  } op_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

endpackage

FILE: hw/rtl/pvc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/pvc_shift.sv
// Modulo-95 shift of one printable byte by one key byte.
module pvc_shift
  import pvc_pkg::*;
(
  input  logic             encrypt,
  input  logic             pass,
  input  logic [7:0]       text,
  input  logic [KEY_W-1:0] key,
  output logic [7:0]       result
);

  logic [8:0] sum;
  logic [8:0] diff;
  logic [8:0] folded;

  always_comb begin
    sum  = {1'b0, text} + {2'b0, key} - {PRINT_LO, 1'b0};
    diff = {1'b0, text} - {2'b0, key};
    if (encrypt) begin
      // sum is 0..188: one subtract brings it under the modulus
      folded = (sum >= PRINT_MOD) ? (sum - PRINT_MOD) : sum;
    end else begin
      folded = diff[8] ? (diff + PRINT_MOD) : diff;
    end
    if (pass) begin
      result = text;
    end else begin
      result = 8'(folded + {1'b0, PRINT_LO});
    end
  end

endmodule

FILE: hw/rtl/printable_vigenere_cipher_unit.sv
// Top level of the printable-ASCII Vigenere cipher unit.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+----------------------------------
//   s_*      | in  | s_tvalid / s_tready     | tuser: operation, tdata: data_byte
//   m_*      | out | m_tvalid / m_tready     | tdata: out_byte
//   apb      | in  | psel, penable, pready=1 | reg 0 at 0x0: encrypt_mode
//
// One beat is taken every cycle unless a stalled output backs up into a full input
// stage; a text beat's result passes through the input stage and the output register.
// The key RAM read is registered, so the key lookup sits between the input stage and the output register.
// Reset clears key length, key position, escape state and all valid flags;
// the key RAM holds no reset and is read only below the key length.
// A stalled output holds one result plus one in the stage behind it.
module printable_vigenere_cipher_unit
  import pvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              encrypt_mode;
  logic [KEY_LW-1:0] key_length;
  logic [KEY_LW-1:0] key_length_next;
  logic [KEY_AW-1:0] key_position;
  logic [KEY_AW-1:0] key_position_next;
  logic              in_escape;
  logic              in_escape_next;

  logic              s1_valid;
  logic              s1_pass;
  logic [7:0]        s1_byte;

  logic              accept;
  logic              advance;
  logic              produces;
  logic              printable;
  logic [KEY_AW-1:0] pos_used;
  logic [KEY_LW-1:0] pos_inc;
  logic              key_wr;
  logic              key_rd;
  logic [KEY_W-1:0]  key_byte;
  logic [7:0]        shifted;
  op_t               op;

  assign op        = op_t'(s_tuser);
  assign printable = is_printable(s_tdata);
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || advance;
  assign accept    = s_tvalid && s_tready;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENCRYPT_MODE) ? {31'b0, encrypt_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      encrypt_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENCRYPT_MODE) begin
      encrypt_mode <= pwdata[0];
    end
  end

  // Key state update
  always_comb begin
    key_length_next   = key_length;
    key_position_next = key_position;
    in_escape_next    = in_escape;
    key_wr            = 1'b0;
    key_rd            = 1'b0;
    produces          = 1'b0;
    pos_used = ({1'b0, key_position} >= key_length) ? '0 : key_position;
    pos_inc  = KEY_LW'({1'b0, pos_used}) + KEY_LW'(1);
    unique case (op)
      OP_CLEAR: begin
        key_length_next   = '0;
        key_position_next = '0;
        in_escape_next    = 1'b0;
      end
      OP_APPEND: begin
        if (in_escape) begin
          if (s_tdata == ESC_END) begin
            in_escape_next = 1'b0;
          end
        end else if (s_tdata == ESC_BYTE) begin
          in_escape_next = 1'b1;
        end else if (printable && key_length < KEY_LW'(KEY_DEPTH)) begin
          key_wr          = 1'b1;
          key_length_next = key_length + KEY_LW'(1);
        end
      end
      OP_REWIND: begin
        key_position_next = '0;
      end
      OP_TEXT: begin
        if (key_length == '0) begin
          produces = 1'b1;
        end else if (printable) begin
          produces          = 1'b1;
          key_rd            = 1'b1;
          key_position_next = (pos_inc >= key_length) ? '0 : pos_inc[KEY_AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length   <= '0;
      key_position <= '0;
      in_escape    <= 1'b0;
    end else if (accept) begin
      key_length   <= key_length_next;
      key_position <= key_position_next;
      in_escape    <= in_escape_next;
    end
  end

  pvc_ram #(
    .WIDTH(KEY_W),
    .DEPTH(KEY_DEPTH),
    .AW   (KEY_AW)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (accept && key_wr),
    .wr_addr(key_length[KEY_AW-1:0]),
    .wr_data(s_tdata[KEY_W-1:0]),
    .rd_en  (accept && key_rd),
    .rd_addr(pos_used),
    .rd_data(key_byte)
  );

  // Input stage: hold the text byte while the key is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept && produces;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produces) begin
      s1_byte <= s_tdata;
      s1_pass <= (key_length == '0);
    end
  end

  pvc_shift u_shift (
    .encrypt(encrypt_mode),
    .pass   (s1_pass),
    .text   (s1_byte),
    .key    (key_byte),
    .result (shifted)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= shifted;
    end
  end

endmodule

FILE: hw/rtl/pvc_checker.sv
// Port-level checker for the cipher unit, bound to the top level.
module pvc_checker
  import pvc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [31:0] prdata
);

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // An empty output never back-pressures the input
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // A fresh result traces back, across the input stage and the output register, to an accepted text beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == OP_TEXT, 2))
    else $error("result without a text beat");

  // Only the mode bit reads back
  assert property (@(posedge clk) disable iff (rst) prdata[31:1] == 31'b0)
    else $error("reserved register bits set");

endmodule

bind printable_vigenere_cipher_unit pvc_checker u_pvc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .prdata  (prdata)
);
